>>> hw/rtl/ptsch_pkg.sv
// Shared types, constants and codes for the priority task scheduler.
package ptsch_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TC_W      = 5;
    localparam int TIME_W    = 24;
    localparam int SW_W      = 16;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SW_W-1:0]   SW_MAX   = {SW_W{1'b1}};

    // Operation codes of an input word.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Register select, taken from paddr[2].
    localparam logic REG_TASK_COUNT = 1'b0;
    localparam logic REG_PREEMPT    = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  urgency;
    } req_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic              idle;
        logic [3:0]        run_slot;
        logic              first_dispatch;
        logic [TIME_W-1:0] response;
        logic              finished;
        logic [TIME_W-1:0] completion;
        logic              switched;
        logic [SW_W-1:0]   switch_total;
        logic              all_done;
    } rsp_word_t;

    // One task table entry as held in the memory.
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  urgency;
        logic [15:0] remaining;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } scan_sample_t;

    typedef struct packed {
        logic             best_found;
        logic [IDX_W-1:0] best_idx;
        entry_t           best_entry;
        logic             cur_ready;
        entry_t           cur_entry;
        logic [CNT_W-1:0] live_count;
    } sel_result_t;

endpackage

>>> hw/rtl/ptsch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/ptsch_select.sv
// Selection unit: one comparator that walks the table entries as they are read.
module ptsch_select (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  ptsch_pkg::scan_sample_t        sample,
    input  logic [ptsch_pkg::TIME_W-1:0]   now,
    input  logic [ptsch_pkg::IDX_W-1:0]    cur_task,
    output ptsch_pkg::sel_result_t         result
);
    import ptsch_pkg::*;

    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    entry_t           best_entry_reg, best_entry_next;
    logic             cur_ready_reg, cur_ready_next;
    entry_t           cur_entry_reg, cur_entry_next;
    logic [CNT_W-1:0] live_count_reg, live_count_next;

    logic ready;
    logic live;

    assign live  = (sample.entry.remaining != '0);
    assign ready = live && ({{(TIME_W-16){1'b0}}, sample.entry.arrival} <= now);

    always_comb
    begin
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        cur_ready_next  = cur_ready_reg;
        cur_entry_next  = cur_entry_reg;
        live_count_next = live_count_reg;
        if (clear)
        begin
            best_found_next = 1'b0;
            cur_ready_next  = 1'b0;
            live_count_next = '0;
        end
        else if (sample.valid)
        begin
            // Strictly smaller wins, so the lowest slot keeps a tie.
            if (ready && (!best_found_reg ||
                          sample.entry.urgency < best_entry_reg.urgency))
            begin
                best_found_next = 1'b1;
                best_idx_next   = sample.idx;
                best_entry_next = sample.entry;
            end
            if (sample.idx == cur_task)
            begin
                cur_ready_next = ready;
                cur_entry_next = sample.entry;
            end
            if (live)
            begin
                live_count_next = live_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            cur_ready_reg  <= 1'b0;
            live_count_reg <= '0;
        end
        else
        begin
            best_found_reg <= best_found_next;
            cur_ready_reg  <= cur_ready_next;
            live_count_reg <= live_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
        cur_entry_reg  <= cur_entry_next;
    end

    assign result.best_found = best_found_reg;
    assign result.best_idx   = best_idx_reg;
    assign result.best_entry = best_entry_reg;
    assign result.cur_ready  = cur_ready_reg;
    assign result.cur_entry  = cur_entry_reg;
    assign result.live_count = live_count_reg;

    as_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= CNT_W'(MAX_TASKS))
        else $error("live task count exceeds the table depth");

    as_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> !best_found_reg && !cur_ready_reg && live_count_reg == '0)
        else $error("selection state not cleared");

    as_found_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !clear && sample.valid && ready |=> best_found_reg)
        else $error("ready task seen but no best recorded");

endmodule

>>> hw/rtl/priority_task_scheduler_unit.sv
// Priority task scheduler top level: task table memory, sequencer and output register.
//
// A load word writes one table slot. For a tick word, the single read port
// of the task table memory delivers the entry of each slot in use, one per
// cycle, to the selection comparator, then the decide step updates the chosen
// entry and fills the output register. That step is held for as long as an
// earlier result still sits in the output register and is stalled. After a
// restart word is accepted, a sweep copies each burst back into the remaining
// time, and no word is accepted during it. The result register lets the next
// word in while a tick result is still waiting to be taken.
module priority_task_scheduler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  ptsch_pkg::req_word_t           req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output ptsch_pkg::rsp_word_t           rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptsch_pkg::ADDR_W-1:0]   paddr,
    input  logic [ptsch_pkg::DATA_W-1:0]   pwdata,
    output logic [ptsch_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import ptsch_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SWEEP
    } state_t;

    state_t               state_reg, state_next;
    logic [TC_W-1:0]      task_count_reg, task_count_next;
    logic                 preempt_reg, preempt_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [IDX_W-1:0]     cur_task_reg, cur_task_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]     prev_task_reg, prev_task_next;
    logic                 prev_valid_reg, prev_valid_next;
    logic [SW_W-1:0]      switch_reg, switch_next;
    logic [MAX_TASKS-1:0] started_reg, started_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_word_t            rsp_reg, rsp_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    scan_sample_t sample;
    sel_result_t  sel;
    logic         sel_clear;

    logic             req_take;
    logic             cfg_write;
    logic [CNT_W-1:0] n_used;
    logic             keep;
    logic             found;
    logic [IDX_W-1:0] pick;
    entry_t           pick_entry;
    logic [15:0]      rem_new;
    logic             fin;
    logic             decide_go;

    ptsch_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sample.valid = rd_pend_reg && (state_reg == ST_SCAN);
    assign sample.idx   = rd_idx_reg;
    assign sample.entry = ram_rdata;

    ptsch_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (sel_clear),
        .sample   (sample),
        .now      (now_reg),
        .cur_task (cur_task_reg),
        .result   (sel)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_TASK_COUNT: prdata = {{(DATA_W-TC_W){1'b0}}, task_count_reg};
            REG_PREEMPT:    prdata = {{(DATA_W-1){1'b0}}, preempt_reg};
            default:        prdata = '0;
        endcase
    end

    assign n_used = (task_count_reg > TC_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                         : CNT_W'(task_count_reg);

    // A non-preemptive task keeps running while it is in range and still ready.
    assign keep = !preempt_reg && cur_valid_reg &&
                  ({1'b0, cur_task_reg} < n_used) && sel.cur_ready;
    assign found      = keep || sel.best_found;
    assign pick       = keep ? cur_task_reg : sel.best_idx;
    assign pick_entry = keep ? sel.cur_entry : sel.best_entry;
    assign rem_new    = pick_entry.remaining - 16'd1;
    assign fin        = found && (rem_new == 16'd0);
    assign decide_go  = (state_reg == ST_DECIDE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next      = state_reg;
        task_count_next = task_count_reg;
        preempt_next    = preempt_reg;
        now_next        = now_reg;
        cur_task_next   = cur_task_reg;
        cur_valid_next  = cur_valid_reg;
        prev_task_next  = prev_task_reg;
        prev_valid_next = prev_valid_reg;
        switch_next     = switch_reg;
        started_next    = started_reg;
        issue_next      = issue_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        sel_clear       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = req.slot[IDX_W-1:0];
        ram_wdata       = '{arrival: req.arrival, burst: req.burst,
                            urgency: req.urgency, remaining: req.burst};
        ram_re          = 1'b0;
        ram_raddr       = issue_reg[IDX_W-1:0];

        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TASK_COUNT: task_count_next = pwdata[TC_W-1:0];
                REG_PREEMPT:    preempt_next    = pwdata[0];
                default:        ;
            endcase
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    case (req.op)
                        OP_LOAD:
                        begin
                            ram_we = 1'b1;
                            started_next[req.slot[IDX_W-1:0]] = 1'b0;
                        end
                        OP_TICK:
                        begin
                            sel_clear  = 1'b1;
                            issue_next = '0;
                            state_next = ST_SCAN;
                        end
                        OP_RESTART:
                        begin
                            now_next        = '0;
                            cur_task_next   = '0;
                            cur_valid_next  = 1'b0;
                            prev_task_next  = '0;
                            prev_valid_next = 1'b0;
                            switch_next     = '0;
                            started_next    = '0;
                            issue_next      = '0;
                            state_next      = ST_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (issue_reg < n_used)
                begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + CNT_W'(1);
                end
                else
                begin
                    // The last entry is taken by the comparator in this cycle.
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (decide_go)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next                 = '0;
                    rsp_next.tick_time       = now_reg;
                    rsp_next.idle            = !found;
                    rsp_next.switch_total    = switch_reg;
                    rsp_next.all_done        = (sel.live_count == {{(CNT_W-1){1'b0}}, fin});
                    if (found)
                    begin
                        rsp_next.run_slot = 4'(pick);
                        if (preempt_reg && prev_valid_reg && prev_task_reg != pick)
                        begin
                            rsp_next.switched = 1'b1;
                            if (switch_reg != SW_MAX)
                            begin
                                switch_next           = switch_reg + SW_W'(1);
                                rsp_next.switch_total = switch_reg + SW_W'(1);
                            end
                        end
                        if (!started_reg[pick])
                        begin
                            started_next[pick]      = 1'b1;
                            rsp_next.first_dispatch = 1'b1;
                            rsp_next.response       = now_reg -
                                {{(TIME_W-16){1'b0}}, pick_entry.arrival};
                        end
                        if (fin)
                        begin
                            rsp_next.finished   = 1'b1;
                            rsp_next.completion = (now_reg == TIME_MAX) ? TIME_MAX
                                                                       : now_reg + TIME_W'(1);
                        end
                        ram_we          = 1'b1;
                        ram_waddr       = pick;
                        ram_wdata       = pick_entry;
                        ram_wdata.remaining = rem_new;
                        cur_task_next   = pick;
                        cur_valid_next  = !fin;
                        prev_task_next  = pick;
                        prev_valid_next = 1'b1;
                    end
                    if (now_reg != TIME_MAX)
                    begin
                        now_next = now_reg + TIME_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                if (issue_reg < CNT_W'(MAX_TASKS))
                begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
                // Write back the entry read in the previous cycle with its burst restored.
                if (rd_pend_reg)
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = rd_idx_reg;
                    ram_wdata           = ram_rdata;
                    ram_wdata.remaining = ram_rdata.burst;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            task_count_reg <= '0;
            preempt_reg    <= 1'b1;
            now_reg        <= '0;
            cur_task_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            prev_task_reg  <= '0;
            prev_valid_reg <= 1'b0;
            switch_reg     <= '0;
            started_reg    <= '0;
            issue_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            task_count_reg <= task_count_next;
            preempt_reg    <= preempt_next;
            now_reg        <= now_next;
            cur_task_reg   <= cur_task_next;
            cur_valid_reg  <= cur_valid_next;
            prev_task_reg  <= prev_task_next;
            prev_valid_reg <= prev_valid_next;
            switch_reg     <= switch_next;
            started_reg    <= started_next;
            issue_reg      <= issue_next;
            rd_pend_reg    <= rd_pend_next;
            rd_idx_reg     <= rd_idx_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    as_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !ram_we)
        else $error("table written while it is being scanned");

    as_restart_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req.op == OP_RESTART |=> now_reg == '0 && switch_reg == '0)
        else $error("restart did not clear time and switch count");

    as_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("result word raised outside the update step");

    as_current_is_previous: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> prev_valid_reg && prev_task_reg == cur_task_reg)
        else $error("dispatched task differs from last running task");

endmodule

>>> verif/ptsch_schedule_checker.sv
// Checker for the priority task scheduler: tracks the task table, predicts each tick word.
module ptsch_schedule_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_stall,
    input  ptsch_pkg::req_word_t         req,
    input  logic                         rsp_valid,
    input  logic                         rsp_stall,
    input  ptsch_pkg::rsp_word_t         rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptsch_pkg::ADDR_W-1:0] paddr,
    input  logic [ptsch_pkg::DATA_W-1:0] pwdata,
    input  logic                         pready,
    output int                           mismatch_count,
    output int                           outstanding
);
    import ptsch_pkg::*;

    logic [15:0]       arrival_q [MAX_TASKS];
    logic [15:0]       burst_q   [MAX_TASKS];
    logic [7:0]        urgency_q [MAX_TASKS];
    logic [15:0]       left_q    [MAX_TASKS];
    logic              started_q [MAX_TASKS];
    logic [TIME_W-1:0] now_q;
    logic [IDX_W-1:0]  dispatched_slot;
    logic              dispatched_live;
    logic [IDX_W-1:0]  last_slot;
    logic              last_live;
    logic [SW_W-1:0]   switch_count;
    logic [TC_W-1:0]   task_count_q;
    logic              preempt_q;

    rsp_word_t expected_ticks [$];
    int        errors_seen = 0;

    assign mismatch_count = errors_seen;

    function automatic logic is_runnable(input int i);
        return (left_q[i] != 16'd0) && (TIME_W'(arrival_q[i]) <= now_q);
    endfunction

    task automatic restart_schedule();
        int i;
        for (i = 0; i < MAX_TASKS; i++)
        begin
            left_q[i]    = burst_q[i];
            started_q[i] = 1'b0;
        end
        now_q           = '0;
        dispatched_slot = '0;
        dispatched_live = 1'b0;
        last_slot       = '0;
        last_live       = 1'b0;
        switch_count    = '0;
    endtask

    task automatic reset_predictor();
        int i;
        for (i = 0; i < MAX_TASKS; i++)
        begin
            arrival_q[i] = '0;
            burst_q[i]   = '0;
            urgency_q[i] = '0;
        end
        task_count_q = '0;
        preempt_q    = 1'b1;
        restart_schedule();
        expected_ticks.delete();
    endtask

    task automatic predict_schedule(input req_word_t w);
        rsp_word_t e;
        int        n;
        int        pick;
        int        i;
        logic      found;
        case (w.op)
            OP_LOAD:
            begin
                arrival_q[w.slot] = w.arrival;
                burst_q[w.slot]   = w.burst;
                urgency_q[w.slot] = w.urgency;
                left_q[w.slot]    = w.burst;
                started_q[w.slot] = 1'b0;
            end
            OP_RESTART:
                restart_schedule();
            OP_TICK:
            begin
                n = (int'(task_count_q) > MAX_TASKS) ? MAX_TASKS : int'(task_count_q);
                e = '0;
                e.tick_time = now_q;
                found = 1'b0;
                pick = 0;
                // A dispatched task keeps the processor in run-to-completion mode only
                // while it is still in use and has time left.
                if (!preempt_q && dispatched_live && int'(dispatched_slot) < n &&
                    is_runnable(int'(dispatched_slot)))
                begin
                    pick  = int'(dispatched_slot);
                    found = 1'b1;
                end
                else
                begin
                    for (i = 0; i < n; i++)
                    begin
                        if (is_runnable(i) && (!found || urgency_q[i] < urgency_q[pick]))
                        begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                begin
                    e.idle = 1'b1;
                end
                else
                begin
                    e.run_slot = IDX_W'(pick);
                    if (preempt_q && last_live && int'(last_slot) != pick)
                    begin
                        e.switched = 1'b1;
                        if (switch_count != SW_MAX)
                            switch_count++;
                    end
                    if (!started_q[pick])
                    begin
                        started_q[pick]  = 1'b1;
                        e.first_dispatch = 1'b1;
                        e.response       = now_q - TIME_W'(arrival_q[pick]);
                    end
                    left_q[pick] = left_q[pick] - 16'd1;
                    if (left_q[pick] == 16'd0)
                    begin
                        e.finished   = 1'b1;
                        e.completion = (now_q != TIME_MAX) ? now_q + TIME_W'(1) : TIME_MAX;
                    end
                    dispatched_slot = IDX_W'(pick);
                    dispatched_live = (left_q[pick] != 16'd0);
                    last_slot       = IDX_W'(pick);
                    last_live       = 1'b1;
                end
                e.switch_total = switch_count;
                e.all_done = 1'b1;
                for (i = 0; i < n; i++)
                begin
                    if (left_q[i] != 16'd0)
                        e.all_done = 1'b0;
                end
                if (now_q != TIME_MAX)
                    now_q++;
                expected_ticks.push_back(e);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors_seen++;
        end
    endtask

    task automatic check_tick(input rsp_word_t got);
        rsp_word_t want;
        if (expected_ticks.size() == 0)
        begin
            $error("tick_time: expected no word, actual %0d", got.tick_time);
            errors_seen++;
        end
        else
        begin
            want = expected_ticks.pop_front();
            check_field("tick_time", 32'(want.tick_time), 32'(got.tick_time));
            check_field("idle", 32'(want.idle), 32'(got.idle));
            check_field("run_slot", 32'(want.run_slot), 32'(got.run_slot));
            check_field("first_dispatch", 32'(want.first_dispatch),
                        32'(got.first_dispatch));
            check_field("response", 32'(want.response), 32'(got.response));
            check_field("finished", 32'(want.finished), 32'(got.finished));
            check_field("completion", 32'(want.completion), 32'(got.completion));
            check_field("switched", 32'(want.switched), 32'(got.switched));
            check_field("switch_total", 32'(want.switch_total), 32'(got.switch_total));
            check_field("all_done", 32'(want.all_done), 32'(got.all_done));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_predictor();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_TASK_COUNT)
                    task_count_q = pwdata[TC_W-1:0];
                else
                    preempt_q = pwdata[0];
            end
            if (rsp_valid && !rsp_stall)
                check_tick(rsp);
            if (req_valid && !req_stall)
                predict_schedule(req);
            outstanding <= expected_ticks.size();
        end
    end

endmodule

>>> verif/tb_priority_task_scheduler_unit.sv
// Testbench top for the priority task scheduler: stimulus, receiver and verdict.
module tb_priority_task_scheduler_unit;
    import ptsch_pkg::*;

    localparam int         ITEM_TARGET     = 1000;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         SETTLE_CYCLES   = 40;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_word_t         req       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rsp_word_t         rsp;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int mismatch_count;
    int outstanding;

    int                   words_taken  = 0;
    logic [MAX_TASKS-1:0] loaded_slots = '0;
    logic                 calm         = 1'b0;
    logic                 hold_off_go  = 1'b0;

    priority_task_scheduler_unit dut (.*);

    ptsch_schedule_checker u_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic req_word_t op_word(input logic [1:0] op);
        req_word_t w;
        w.op      = op;
        w.slot    = 4'($urandom);
        w.arrival = 16'($urandom);
        w.burst   = 16'($urandom);
        w.urgency = 8'($urandom);
        return w;
    endfunction

    function automatic req_word_t load_word(input int slot, input int arr, input int len,
                                            input int urg);
        req_word_t w;
        w.op      = OP_LOAD;
        w.slot    = 4'(slot);
        w.arrival = 16'(arr);
        w.burst   = 16'(len);
        w.urgency = 8'(urg);
        return w;
    endfunction

    // Mostly short tasks that arrive early, with a few zero, huge or late ones.
    function automatic req_word_t random_load(input int slot);
        int arr;
        int len;
        int urg;
        int pick;
        pick = $urandom_range(0, 99);
        arr  = (pick < 6) ? int'($urandom_range(0, 65535)) : int'($urandom_range(0, 30));
        pick = $urandom_range(0, 99);
        if (pick < 3)
            len = 0;
        else if (pick < 6)
            len = $urandom_range(0, 65535);
        else if (pick < 8)
            len = 65535;
        else
            len = $urandom_range(1, 6);
        urg = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 3))
                                          : int'($urandom_range(0, 255));
        return load_word(slot, arr, len, urg);
    endfunction

    task automatic send_word(input req_word_t w);
        int gap;
        if (!calm && $urandom_range(0, 99) < 15)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (w.op != OP_UNUSED)
            words_taken++;
        if (w.op == OP_LOAD)
            loaded_slots[w.slot] = 1'b1;
    endtask

    // Waits until every tick result has come back and the block has gone quiet.
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input int value);
        logic [DATA_W-1:0] data;
        data = $urandom;
        if (sel == REG_TASK_COUNT)
            data[TC_W-1:0] = TC_W'(value);
        else
            data[0] = value[0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : receiver
        int   waited;
        logic held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !held)
            begin
                // One long hold-off so that the block fills up and stalls its input.
                held = 1'b1;
                rsp_stall <= 1'b1;
                for (waited = 0; waited < HOLD_OFF_CYCLES; waited++)
                    @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (calm || !rst_n)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 99) < 10);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_priority_task_scheduler_unit NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int pick;
        int cur_count;
        int in_use;
        int ticks;
        int s;
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing in use yet: the tick is idle and everything counts as done.
        send_word(op_word(OP_TICK));
        drain();
        write_reg(REG_TASK_COUNT, 4);
        write_reg(REG_PREEMPT, 1);
        send_word(load_word(0, 0, 2, 255));
        send_word(load_word(1, 1, 1, 0));
        send_word(load_word(2, 65535, 65535, 0));
        send_word(load_word(3, 0, 0, 0));
        send_word(op_word(OP_UNUSED));
        repeat (4) send_word(op_word(OP_TICK));
        send_word(op_word(OP_RESTART));
        drain();
        // Run to completion: slot 0 keeps going although slot 1 has a smaller number.
        write_reg(REG_PREEMPT, 0);
        repeat (3) send_word(op_word(OP_TICK));
        send_word(op_word(OP_RESTART));
        send_word(op_word(OP_TICK));
        drain();
        // Back to preemptive with slot 0 still dispatched.
        write_reg(REG_PREEMPT, 1);
        send_word(op_word(OP_TICK));
        cur_count = 4;

        phase = 0;
        while (words_taken < ITEM_TARGET)
        begin
            drain();
            if ($urandom_range(0, 9) < 7)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    cur_count = 0;
                else if (pick == 1)
                    cur_count = MAX_TASKS;
                else if (pick == 2)
                    cur_count = $urandom_range(MAX_TASKS + 1, 31);
                else if (pick < 5)
                    cur_count = $urandom_range(7, 15);
                else
                    cur_count = $urandom_range(1, 6);
                write_reg(REG_TASK_COUNT, cur_count);
            end
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_PREEMPT, $urandom_range(0, 1));
            in_use = (cur_count > MAX_TASKS) ? MAX_TASKS : cur_count;
            calm <= (phase >= 6 && phase < 10);
            if ($urandom_range(0, 9) < 6)
                send_word(op_word(OP_RESTART));
            // Every slot in use must hold a task before a tick reads it.
            for (s = 0; s < in_use; s++)
            begin
                if (!loaded_slots[s] || $urandom_range(0, 2) == 0)
                    send_word(random_load(s));
            end
            if (phase == 3)
                hold_off_go <= 1'b1;
            ticks = (phase == 3) ? 80 : $urandom_range(4, 40);
            for (k = 0; k < ticks; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_word(random_load($urandom_range(0, MAX_TASKS - 1)));
                else if (pick < 7)
                    send_word(op_word(OP_RESTART));
                else if (pick < 9)
                    send_word(op_word(OP_UNUSED));
                else
                    send_word(op_word(OP_TICK));
            end
            phase++;
        end

        drain();
        if (mismatch_count == 0 && outstanding == 0)
            $display("tb_priority_task_scheduler_unit OK");
        else
            $display("tb_priority_task_scheduler_unit NOT OK");
        $finish;
    end

endmodule
